// ===== src/segment_segment_distance_sq_top_assert.svh =====
// ----------------------------------------------------------------------------
// Segment distance assertion macros
// Shared concurrent assertion forms for the segment distance block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_DISTANCE_SQ_TOP_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_SQ_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment distance assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment distance assertion failed");

`endif

// ===== src/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment distance package
// Widths, types and constants shared by the segment distance modules.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DW          = COORD_WIDTH + 1;
  localparam int PW          = 2 * DW;
  localparam int DOTW        = PW + 2;
  localparam int MH          = (DOTW + 1) / 2;
  localparam int QW          = 2 * DOTW;
  localparam int PB          = 16;
  localparam int SW          = PB + 1;
  localparam int TW          = DOTW + SW + 1;
  localparam int CW          = DW + SW + 1;
  localparam int SH          = CW / 2;
  localparam int SQW         = 2 * CW;
  localparam int SUMW        = SQW + 2;
  localparam int OUTW        = 50;
  localparam int TRUNC       = 32;
  localparam int THW         = 16;
  localparam int SIDE_LEN    = PB + 4;
  localparam int TAIL_LEN    = PB + 2;
  localparam int LAT         = 3 + 3 + (PB + 1) + 3 + (PB + 1) + 5;

  localparam logic [THW-1:0] THRESHOLD_RESET = 16'd17;
  localparam logic [SW-1:0]  PARAM_ONE       = {1'b1, {PB{1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DW-1:0]          dif_t;
  typedef logic signed [DOTW-1:0]        dot_t;
  typedef logic [DOTW-1:0]               mag_t;
  typedef logic signed [QW-1:0]          wide_t;
  typedef logic [QW-1:0]                 wideu_t;
  typedef logic signed [TW-1:0]          tw_t;
  typedef logic [SW-1:0]                 quo_t;
  typedef logic signed [CW-1:0]          cw_t;
  typedef logic [CW-1:0]                 am_t;
  typedef logic [SQW-1:0]                sq_t;
  typedef logic [SUMW-1:0]               sum_t;

  typedef struct packed {
    coord_t [2:0] p1;
    coord_t [2:0] q1;
    coord_t [2:0] p2;
    coord_t [2:0] q2;
  } seg_t;

  typedef struct packed {
    dif_t [2:0] d1;
    dif_t [2:0] d2;
    dif_t [2:0] r;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t e;
    dot_t f;
    logic adeg;
    logic edeg;
  } dots_t;

  typedef struct packed {
    geo_t  geo;
    dots_t dots;
  } side_t;

  typedef struct packed {
    geo_t geo;
    logic to_t;
    quo_t fixed;
  } tail_t;

endpackage

// ===== src/ssd_if.sv =====
// ----------------------------------------------------------------------------
// Segment distance channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic valid;
  logic ready;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_start_x;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_start_y;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_start_z;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_end_x;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_end_y;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] first_end_z;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_start_x;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_start_y;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_start_z;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_end_x;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_end_y;
  logic signed [ssd_pkg::COORD_WIDTH-1:0] second_end_z;

  modport source (
    output valid, first_start_x, first_start_y, first_start_z,
    output first_end_x, first_end_y, first_end_z,
    output second_start_x, second_start_y, second_start_z,
    output second_end_x, second_end_y, second_end_z,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_start_z,
    input  first_end_x, first_end_y, first_end_z,
    input  second_start_x, second_start_y, second_start_z,
    input  second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic [ssd_pkg::OUTW-1:0] distance_squared;

  modport source (output valid, distance_squared, input ready);
  modport sink (input valid, distance_squared, output ready);
endinterface

interface ssd_cfg_if;
  logic valid;
  logic ready;
  logic [ssd_pkg::THW-1:0] degenerate_threshold;

  modport source (output valid, degenerate_threshold, input ready);
  modport sink (input valid, degenerate_threshold, output ready);
endinterface

// ===== src/ssd_mul.sv =====
// ----------------------------------------------------------------------------
// Segment distance wide multiplier
// Two-stage signed multiplier built from four registered partial products.
// ----------------------------------------------------------------------------
module ssd_mul (
  input  logic          clk,
  input  logic          en,
  input  ssd_pkg::dot_t x,
  input  ssd_pkg::dot_t y,
  output ssd_pkg::wide_t p
);

  ssd_pkg::mag_t xm;
  ssd_pkg::mag_t ym;
  logic [2*(ssd_pkg::DOTW-ssd_pkg::MH)-1:0] hh;
  logic [ssd_pkg::DOTW-1:0]                 hl;
  logic [ssd_pkg::DOTW-1:0]                 lh;
  logic [2*ssd_pkg::MH-1:0]                 ll;
  logic                                     neg;
  ssd_pkg::wideu_t                          sum;

  always_comb begin
    xm = x[ssd_pkg::DOTW-1] ? ssd_pkg::mag_t'(-x) : ssd_pkg::mag_t'(x);
    ym = y[ssd_pkg::DOTW-1] ? ssd_pkg::mag_t'(-y) : ssd_pkg::mag_t'(y);
  end

  always_comb begin
    sum = (ssd_pkg::wideu_t'(hh) << (2 * ssd_pkg::MH))
        + ((ssd_pkg::wideu_t'(hl) + ssd_pkg::wideu_t'(lh)) << ssd_pkg::MH)
        + ssd_pkg::wideu_t'(ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh  <= xm[ssd_pkg::DOTW-1:ssd_pkg::MH] * ym[ssd_pkg::DOTW-1:ssd_pkg::MH];
      hl  <= xm[ssd_pkg::DOTW-1:ssd_pkg::MH] * ym[ssd_pkg::MH-1:0];
      lh  <= xm[ssd_pkg::MH-1:0] * ym[ssd_pkg::DOTW-1:ssd_pkg::MH];
      ll  <= xm[ssd_pkg::MH-1:0] * ym[ssd_pkg::MH-1:0];
      neg <= x[ssd_pkg::DOTW-1] ^ y[ssd_pkg::DOTW-1];
      p   <= neg ? ssd_pkg::wide_t'(-sum) : ssd_pkg::wide_t'(sum);
    end
  end

endmodule

// ===== src/ssd_div.sv =====
// ----------------------------------------------------------------------------
// Segment distance parameter divider
// Pipelined restoring divider giving a clamped Q1.16 quotient in [0, 1].
// ----------------------------------------------------------------------------
module ssd_div (
  input  logic           clk,
  input  logic           en,
  input  ssd_pkg::wide_t num,
  input  ssd_pkg::wide_t den,
  output ssd_pkg::quo_t  q
);

  ssd_pkg::wideu_t         rem  [0:ssd_pkg::PB];
  ssd_pkg::wideu_t         dv   [0:ssd_pkg::PB];
  logic [ssd_pkg::PB-1:0]  qb   [0:ssd_pkg::PB];
  logic                    zero [0:ssd_pkg::PB];
  logic                    one  [0:ssd_pkg::PB];
  ssd_pkg::wideu_t         sh   [0:ssd_pkg::PB-1];
  logic                    ge   [0:ssd_pkg::PB-1];

  always_comb begin
    for (int k = 0; k < ssd_pkg::PB; k++) begin
      sh[k] = {rem[k][ssd_pkg::QW-2:0], 1'b0};
      ge[k] = sh[k] >= dv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= num[ssd_pkg::QW-1] || (num == '0) || den[ssd_pkg::QW-1] || (den == '0);
      one[0]  <= num >= den;
      rem[0]  <= ssd_pkg::wideu_t'(num);
      dv[0]   <= ssd_pkg::wideu_t'(den);
      qb[0]   <= '0;
      for (int k = 0; k < ssd_pkg::PB; k++) begin
        rem[k+1]  <= ge[k] ? sh[k] - dv[k] : sh[k];
        dv[k+1]   <= dv[k];
        qb[k+1]   <= {qb[k][ssd_pkg::PB-2:0], ge[k]};
        zero[k+1] <= zero[k];
        one[k+1]  <= one[k];
      end
    end
  end

  always_comb begin
    if (zero[ssd_pkg::PB]) begin
      q = '0;
    end else if (one[ssd_pkg::PB]) begin
      q = ssd_pkg::PARAM_ONE;
    end else begin
      q = {1'b0, qb[ssd_pkg::PB]};
    end
  end

endmodule

// ===== src/ssd_front.sv =====
// ----------------------------------------------------------------------------
// Segment distance front end
// Direction vectors, dot products and degeneracy flags over three stages.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                      clk,
  input  logic                      en,
  input  ssd_pkg::seg_t             seg,
  input  logic [ssd_pkg::THW-1:0]   threshold,
  output ssd_pkg::geo_t             geo,
  output ssd_pkg::dots_t            dots
);

  ssd_pkg::geo_t                 geo1;
  ssd_pkg::geo_t                 geo2;
  logic signed [ssd_pkg::PW-1:0] pa [3];
  logic signed [ssd_pkg::PW-1:0] pe [3];
  logic signed [ssd_pkg::PW-1:0] pf [3];
  logic signed [ssd_pkg::PW-1:0] pc [3];
  logic signed [ssd_pkg::PW-1:0] pb [3];
  ssd_pkg::dot_t                 sa;
  ssd_pkg::dot_t                 se;

  always_comb begin
    sa = ssd_pkg::dot_t'(pa[0]) + ssd_pkg::dot_t'(pa[1]) + ssd_pkg::dot_t'(pa[2]);
    se = ssd_pkg::dot_t'(pe[0]) + ssd_pkg::dot_t'(pe[1]) + ssd_pkg::dot_t'(pe[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        geo1.d1[i] <= ssd_pkg::dif_t'(seg.q1[i]) - ssd_pkg::dif_t'(seg.p1[i]);
        geo1.d2[i] <= ssd_pkg::dif_t'(seg.q2[i]) - ssd_pkg::dif_t'(seg.p2[i]);
        geo1.r[i]  <= ssd_pkg::dif_t'(seg.p1[i]) - ssd_pkg::dif_t'(seg.p2[i]);
        pa[i] <= geo1.d1[i] * geo1.d1[i];
        pe[i] <= geo1.d2[i] * geo1.d2[i];
        pf[i] <= geo1.d2[i] * geo1.r[i];
        pc[i] <= geo1.d1[i] * geo1.r[i];
        pb[i] <= geo1.d1[i] * geo1.d2[i];
      end
      geo2    <= geo1;
      geo     <= geo2;
      dots.a  <= sa;
      dots.e  <= se;
      dots.f  <= ssd_pkg::dot_t'(pf[0]) + ssd_pkg::dot_t'(pf[1]) + ssd_pkg::dot_t'(pf[2]);
      dots.c  <= ssd_pkg::dot_t'(pc[0]) + ssd_pkg::dot_t'(pc[1]) + ssd_pkg::dot_t'(pc[2]);
      dots.b  <= ssd_pkg::dot_t'(pb[0]) + ssd_pkg::dot_t'(pb[1]) + ssd_pkg::dot_t'(pb[2]);
      dots.adeg <= sa <= ssd_pkg::dot_t'(threshold);
      dots.edeg <= se <= ssd_pkg::dot_t'(threshold);
    end
  end

endmodule

// ===== src/ssd_back.sv =====
// ----------------------------------------------------------------------------
// Segment distance back end
// Closest-point difference, split squaring and saturating sum over five stages.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                     clk,
  input  logic                     en,
  input  ssd_pkg::geo_t            geo,
  input  ssd_pkg::quo_t            s,
  input  ssd_pkg::quo_t            t,
  output logic [ssd_pkg::OUTW-1:0] dsq
);

  ssd_pkg::cw_t  ps [3];
  ssd_pkg::cw_t  pt [3];
  ssd_pkg::dif_t rr [3];
  ssd_pkg::cw_t  comp [3];
  ssd_pkg::am_t  am [3];
  logic [2*(ssd_pkg::CW-ssd_pkg::SH)-1:0] hh [3];
  logic [ssd_pkg::CW-1:0]                 hl [3];
  logic [2*ssd_pkg::SH-1:0]               ll [3];
  ssd_pkg::sq_t  sq [3];
  ssd_pkg::sum_t sum;
  ssd_pkg::sum_t shifted;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = (ssd_pkg::cw_t'(rr[i]) <<< ssd_pkg::PB) + ps[i] - pt[i];
    end
    sum     = ssd_pkg::sum_t'(sq[0]) + ssd_pkg::sum_t'(sq[1]) + ssd_pkg::sum_t'(sq[2]);
    shifted = sum >> ssd_pkg::TRUNC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ps[i] <= geo.d1[i] * $signed({1'b0, s});
        pt[i] <= geo.d2[i] * $signed({1'b0, t});
        rr[i] <= geo.r[i];
        am[i] <= comp[i][ssd_pkg::CW-1] ? ssd_pkg::am_t'(-comp[i]) : ssd_pkg::am_t'(comp[i]);
        hh[i] <= am[i][ssd_pkg::CW-1:ssd_pkg::SH] * am[i][ssd_pkg::CW-1:ssd_pkg::SH];
        hl[i] <= am[i][ssd_pkg::CW-1:ssd_pkg::SH] * am[i][ssd_pkg::SH-1:0];
        ll[i] <= am[i][ssd_pkg::SH-1:0] * am[i][ssd_pkg::SH-1:0];
        sq[i] <= (ssd_pkg::sq_t'(hh[i]) << (2 * ssd_pkg::SH))
               + (ssd_pkg::sq_t'(hl[i]) << (ssd_pkg::SH + 1))
               + ssd_pkg::sq_t'(ll[i]);
      end
      if (|shifted[ssd_pkg::SUMW-1:ssd_pkg::OUTW]) begin
        dsq <= '1;
      end else begin
        dsq <= shifted[ssd_pkg::OUTW-1:0];
      end
    end
  end

endmodule

// ===== src/segment_segment_distance_sq_top.sv =====
// ----------------------------------------------------------------------------
// Segment to segment squared distance
// Top level: closest-point parameter solve and squared distance pipeline.
// ----------------------------------------------------------------------------
// The block takes one pair of segments per clock cycle while no result waits
// at the output, and returns each squared distance in input order.
// The latency is set mostly by two 17-stage restoring dividers in series,
// one for the unconstrained parameter on the first segment and one for the
// clamped recomputation. When a result waits at the output, the whole
// pipeline holds and the input channel stops taking transactions. The
// threshold register may be written only while no transaction is in flight.
`include "segment_segment_distance_sq_top_assert.svh"

module segment_segment_distance_sq_top (
  input  logic             clk,
  input  logic             rst,
  ssd_in_if.sink           seg_in,
  ssd_out_if.source        dist_out,
  ssd_cfg_if.sink          cfg
);

  logic [ssd_pkg::THW-1:0] threshold;
  logic [ssd_pkg::LAT-1:0] vld;
  logic                    en;
  ssd_pkg::seg_t           seg;
  ssd_pkg::geo_t           geo_f;
  ssd_pkg::dots_t          dots_f;
  ssd_pkg::wide_t          p_ae;
  ssd_pkg::wide_t          p_bb;
  ssd_pkg::wide_t          p_bf;
  ssd_pkg::wide_t          p_ce;
  ssd_pkg::wide_t          denom;
  ssd_pkg::wide_t          n1;
  ssd_pkg::quo_t           s1;
  ssd_pkg::side_t          side [0:ssd_pkg::SIDE_LEN-1];
  ssd_pkg::side_t          sd1;
  ssd_pkg::side_t          sd2;
  ssd_pkg::quo_t           s1_1;
  ssd_pkg::quo_t           s1_2;
  ssd_pkg::tw_t            bs;
  ssd_pkg::tw_t            tnum;
  ssd_pkg::tw_t            eden;
  ssd_pkg::wide_t          num2_next;
  ssd_pkg::wide_t          den2_next;
  ssd_pkg::tail_t          tail_next;
  ssd_pkg::wide_t          num2;
  ssd_pkg::wide_t          den2;
  ssd_pkg::tail_t          tl [0:ssd_pkg::TAIL_LEN-1];
  ssd_pkg::quo_t           q2;
  ssd_pkg::quo_t           s_fin;
  ssd_pkg::quo_t           t_fin;

  assign cfg.ready      = 1'b1;
  assign en             = !vld[ssd_pkg::LAT-1] || dist_out.ready;
  assign seg_in.ready   = en;
  assign dist_out.valid = vld[ssd_pkg::LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ssd_pkg::THRESHOLD_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.degenerate_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ssd_pkg::LAT-2:0], seg_in.valid};
    end
  end

  always_comb begin
    seg.p1[0] = seg_in.first_start_x;
    seg.p1[1] = seg_in.first_start_y;
    seg.p1[2] = seg_in.first_start_z;
    seg.q1[0] = seg_in.first_end_x;
    seg.q1[1] = seg_in.first_end_y;
    seg.q1[2] = seg_in.first_end_z;
    seg.p2[0] = seg_in.second_start_x;
    seg.p2[1] = seg_in.second_start_y;
    seg.p2[2] = seg_in.second_start_z;
    seg.q2[0] = seg_in.second_end_x;
    seg.q2[1] = seg_in.second_end_y;
    seg.q2[2] = seg_in.second_end_z;
  end

  ssd_front u_front (
    .clk       (clk),
    .en        (en),
    .seg       (seg),
    .threshold (threshold),
    .geo       (geo_f),
    .dots      (dots_f)
  );

  ssd_mul u_mul_ae (.clk(clk), .en(en), .x(dots_f.a), .y(dots_f.e), .p(p_ae));
  ssd_mul u_mul_bb (.clk(clk), .en(en), .x(dots_f.b), .y(dots_f.b), .p(p_bb));
  ssd_mul u_mul_bf (.clk(clk), .en(en), .x(dots_f.b), .y(dots_f.f), .p(p_bf));
  ssd_mul u_mul_ce (.clk(clk), .en(en), .x(dots_f.c), .y(dots_f.e), .p(p_ce));

  always_ff @(posedge clk) begin
    if (en) begin
      denom <= p_ae - p_bb;
      n1    <= p_bf - p_ce;
    end
  end

  ssd_div u_div_s (.clk(clk), .en(en), .num(n1), .den(denom), .q(s1));

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{geo: geo_f, dots: dots_f};
      for (int k = 1; k < ssd_pkg::SIDE_LEN; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bs   <= side[ssd_pkg::SIDE_LEN-1].dots.b * $signed({1'b0, s1});
      sd1  <= side[ssd_pkg::SIDE_LEN-1];
      s1_1 <= s1;
      tnum <= bs + (ssd_pkg::tw_t'(sd1.dots.f) <<< ssd_pkg::PB);
      eden <= ssd_pkg::tw_t'(sd1.dots.e) <<< ssd_pkg::PB;
      sd2  <= sd1;
      s1_2 <= s1_1;
    end
  end

  always_comb begin
    tail_next.geo   = sd2.geo;
    tail_next.to_t  = 1'b0;
    tail_next.fixed = '0;
    num2_next       = '0;
    den2_next       = ssd_pkg::wide_t'(sd2.dots.a);
    if (sd2.dots.adeg && sd2.dots.edeg) begin
      num2_next = '0;
    end else if (sd2.dots.adeg) begin
      num2_next      = ssd_pkg::wide_t'(sd2.dots.f);
      den2_next      = ssd_pkg::wide_t'(sd2.dots.e);
      tail_next.to_t = 1'b1;
    end else if (sd2.dots.edeg || tnum[ssd_pkg::TW-1]) begin
      num2_next = -ssd_pkg::wide_t'(sd2.dots.c);
    end else if (tnum > eden) begin
      num2_next       = ssd_pkg::wide_t'(sd2.dots.b) - ssd_pkg::wide_t'(sd2.dots.c);
      tail_next.fixed = ssd_pkg::PARAM_ONE;
    end else begin
      num2_next       = ssd_pkg::wide_t'(tnum);
      den2_next       = ssd_pkg::wide_t'(eden);
      tail_next.to_t  = 1'b1;
      tail_next.fixed = s1_2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2  <= num2_next;
      den2  <= den2_next;
      tl[0] <= tail_next;
      for (int k = 1; k < ssd_pkg::TAIL_LEN; k++) begin
        tl[k] <= tl[k-1];
      end
    end
  end

  ssd_div u_div_t (.clk(clk), .en(en), .num(num2), .den(den2), .q(q2));

  always_comb begin
    s_fin = tl[ssd_pkg::TAIL_LEN-1].to_t ? tl[ssd_pkg::TAIL_LEN-1].fixed : q2;
    t_fin = tl[ssd_pkg::TAIL_LEN-1].to_t ? q2 : tl[ssd_pkg::TAIL_LEN-1].fixed;
  end

  ssd_back u_back (
    .clk  (clk),
    .en   (en),
    .geo  (tl[ssd_pkg::TAIL_LEN-1].geo),
    .s    (s_fin),
    .t    (t_fin),
    .dsq  (dist_out.distance_squared)
  );

  `SSD_ASSERT_NEXT(a_reset_clears_out, clk, 1'b0, rst, !dist_out.valid)
  `SSD_ASSERT_NEXT(a_accept_enters, clk, rst, seg_in.valid && seg_in.ready, vld[0])
  `SSD_ASSERT_NOW(a_stall_blocks_in, clk, rst, dist_out.valid && !dist_out.ready, !seg_in.ready)

endmodule
